[rtl/mmp_pkg.sv]
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared constants, operation codes and the cell control word for the
// modular matrix power block.
// ----------------------------------------------------------------------------
package mmp_pkg;

    // Field widths
    localparam int MOD_W = 30;          // width of one residue
    localparam int ROW_W = 4;           // row/column index, room for 16
    localparam int DIM_W = 5;           // dimension, room for 16 itself

    // Prime modulus and Barrett constant floor(2^60 / P)
    localparam logic [MOD_W-1:0] MOD_P   = 30'd1000000007;
    localparam logic [30:0]      BARRETT = 31'd1152921496;

    // Cycles to wait after the last issue before the accumulators are final
    localparam int DRAIN_CYC = 6;

    // Cell operation codes
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_INIT   = 3'd2;
    localparam logic [2:0] OP_RING   = 3'd3;
    localparam logic [2:0] OP_ISSUE  = 3'd4;
    localparam logic [2:0] OP_COMMIT = 3'd5;
    localparam logic [2:0] OP_COPY   = 3'd6;
    localparam logic [2:0] OP_SHIFT  = 3'd7;

    // Control word broadcast to every cell
    typedef struct packed {
        logic [2:0]       op;
        logic             src_res;  // ring load from result, else scratch
        logic             mul;      // product into result, else square scratch
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [DIM_W-1:0] dim;
        logic [MOD_W-1:0] value;
    } mmp_ctrl_t;

endpackage

[rtl/mmp_mulmod.sv]
// ----------------------------------------------------------------------------
// mmp_mulmod
// Pipelined modular multiplier, a * b mod P by Barrett reduction, four stages.
// ----------------------------------------------------------------------------
module mmp_mulmod
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [mmp_pkg::MOD_W-1:0] a,
    input  logic [mmp_pkg::MOD_W-1:0] b,
    output logic                      prod_valid,
    output logic [mmp_pkg::MOD_W-1:0] prod
);

    logic [59:0] x_reg;
    logic [30:0] q_reg;
    logic [31:0] xl_reg;
    logic [31:0] r_reg;
    logic [mmp_pkg::MOD_W-1:0] p_reg;
    logic [3:0]  v_reg;

    logic [61:0] qfull;
    logic [60:0] qp;
    logic [31:0] two_p;
    logic [31:0] one_p;
    logic [31:0] red;

    assign qfull = x_reg[59:29] * mmp_pkg::BARRETT;
    assign qp    = q_reg * mmp_pkg::MOD_P;
    assign one_p = 32'(mmp_pkg::MOD_P);
    assign two_p = 32'({mmp_pkg::MOD_P, 1'b0});

    // remainder stays below three times the modulus
    always_comb
    begin
        if (r_reg >= two_p)
        begin
            red = r_reg - two_p;
        end
        else if (r_reg >= one_p)
        begin
            red = r_reg - one_p;
        end
        else
        begin
            red = r_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= a * b;
        q_reg  <= qfull[61:31];
        xl_reg <= x_reg[31:0];
        r_reg  <= xl_reg - qp[31:0];
        p_reg  <= red[mmp_pkg::MOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    assign prod_valid = v_reg[3];
    assign prod       = p_reg;

endmodule

[rtl/mmp_cell.sv]
// ----------------------------------------------------------------------------
// mmp_cell
// One column of the base, scratch, result and product matrices, with its own
// multiplier and accumulator; the ring register passes row values along.
// ----------------------------------------------------------------------------
module mmp_cell
#(
    parameter int MAX_DIM = 8,
    parameter int CELL_IX = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mmp_pkg::mmp_ctrl_t        ctrl,
    input  logic [mmp_pkg::MOD_W-1:0] ring_in,
    output logic [mmp_pkg::MOD_W-1:0] ring_out
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [IW-1:0]             SELF   = IW'(CELL_IX);
    localparam logic [mmp_pkg::DIM_W-1:0] SELF_D = mmp_pkg::DIM_W'(CELL_IX);

    logic [mmp_pkg::MOD_W-1:0] base_reg [MAX_DIM];
    logic [mmp_pkg::MOD_W-1:0] scr_reg  [MAX_DIM];
    logic [mmp_pkg::MOD_W-1:0] res_reg  [MAX_DIM];
    logic [mmp_pkg::MOD_W-1:0] tmp_reg  [MAX_DIM];
    logic [mmp_pkg::MOD_W-1:0] ring_reg;
    logic [mmp_pkg::MOD_W-1:0] acc_reg;
    logic [mmp_pkg::MOD_W-1:0] acc_next;
    logic [IW-1:0]             k_reg;
    logic [IW-1:0]             k_next;

    logic [IW-1:0]             row_ix;
    logic [IW-1:0]             rd_ix;
    logic [mmp_pkg::MOD_W-1:0] rd_res;
    logic [mmp_pkg::MOD_W-1:0] rd_scr;
    logic [mmp_pkg::DIM_W-1:0] k_inc;
    logic                      issue;
    logic                      mm_valid;
    logic [mmp_pkg::MOD_W-1:0] mm_prod;
    logic [mmp_pkg::MOD_W:0]   acc_sum;

    assign row_ix = ctrl.row[IW-1:0];
    assign issue  = (ctrl.op == mmp_pkg::OP_ISSUE);
    assign rd_ix  = issue ? k_reg : row_ix;
    assign rd_res = res_reg[rd_ix];
    assign rd_scr = scr_reg[rd_ix];
    assign k_inc  = mmp_pkg::DIM_W'(k_reg) + mmp_pkg::DIM_W'(1);
    assign k_next = (k_inc == ctrl.dim) ? '0 : k_inc[IW-1:0];

    mmp_mulmod u_mulmod
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (issue),
        .a          (ring_reg),
        .b          (ctrl.mul ? rd_res : rd_scr),
        .prod_valid (mm_valid),
        .prod       (mm_prod)
    );

    assign acc_sum = (mmp_pkg::MOD_W + 1)'(acc_reg) + (mmp_pkg::MOD_W + 1)'(mm_prod);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.op == mmp_pkg::OP_INIT || ctrl.op == mmp_pkg::OP_COMMIT)
        begin
            acc_next = '0;
        end
        else if (mm_valid)
        begin
            if (acc_sum >= (mmp_pkg::MOD_W + 1)'(mmp_pkg::MOD_P))
            begin
                acc_next = mmp_pkg::MOD_W'(acc_sum - (mmp_pkg::MOD_W + 1)'(mmp_pkg::MOD_P));
            end
            else
            begin
                acc_next = acc_sum[mmp_pkg::MOD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        unique case (ctrl.op)
            mmp_pkg::OP_LOAD:
            begin
                if (ctrl.col[IW-1:0] == SELF && mmp_pkg::DIM_W'(ctrl.col) == SELF_D)
                begin
                    base_reg[row_ix] <= ctrl.value;
                end
            end
            mmp_pkg::OP_INIT:
            begin
                for (int i = 0; i < MAX_DIM; i++)
                begin
                    scr_reg[i] <= base_reg[i];
                    res_reg[i] <= (i == CELL_IX && SELF_D < ctrl.dim) ?
                                  mmp_pkg::MOD_W'(1) : '0;
                end
            end
            mmp_pkg::OP_RING:
            begin
                ring_reg <= ctrl.src_res ? rd_res : rd_scr;
                k_reg    <= SELF;
            end
            mmp_pkg::OP_ISSUE:
            begin
                ring_reg <= ring_in;
                k_reg    <= k_next;
            end
            mmp_pkg::OP_COMMIT:
            begin
                tmp_reg[row_ix] <= acc_reg;
            end
            mmp_pkg::OP_COPY:
            begin
                for (int i = 0; i < MAX_DIM; i++)
                begin
                    if (ctrl.mul)
                    begin
                        res_reg[i] <= tmp_reg[i];
                    end
                    else
                    begin
                        scr_reg[i] <= tmp_reg[i];
                    end
                end
            end
            mmp_pkg::OP_SHIFT:
            begin
                ring_reg <= ring_in;
            end
            default:
            begin
                ring_reg <= ring_reg;
            end
        endcase
    end

    assign ring_out = ring_reg;

endmodule

[rtl/modular_matrix_power.sv]
// Operation: a start word runs the products for each exponent bit on the
//   single row of d multiply cells, d being the dimension, that every
//   product streams through row by row; then d * d output words follow,
//   each row reloaded into the ring ahead of its d words.
// Input: one word at a time, taken only while idle; a load is stored at
//   once, while a start word holds off all input until its last result word.
// Reset: control clears, dimension returns to 2; stored matrices are kept.
// ----------------------------------------------------------------------------
// modular_matrix_power
// Matrix power modulo 1000000007 by repeated squaring on a ring of cells.
// ----------------------------------------------------------------------------
module modular_matrix_power
#(
    parameter int MAX_DIM = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write_en,
    input  logic [3:0]  cfg_write_data,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [2:0]  row_index,
    input  logic [2:0]  col_index,
    input  logic [29:0] entry_value,
    input  logic [62:0] exponent,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_row,
    output logic [2:0]  out_col,
    output logic [29:0] out_value,
    output logic        last
);

    // Sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_STEP   = 4'd2;
    localparam logic [3:0] S_RING   = 4'd3;
    localparam logic [3:0] S_ISSUE  = 4'd4;
    localparam logic [3:0] S_DRAIN  = 4'd5;
    localparam logic [3:0] S_COMMIT = 4'd6;
    localparam logic [3:0] S_COPY   = 4'd7;
    localparam logic [3:0] S_OLOAD  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    localparam int DW = mmp_pkg::DIM_W;
    localparam int RW = mmp_pkg::ROW_W;

    logic [3:0]    state_reg;
    logic [3:0]    state_next;
    logic [62:0]   exp_reg;
    logic [62:0]   exp_next;
    logic          mul_reg;
    logic          mul_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [RW-1:0] ocol_reg;
    logic [RW-1:0] ocol_next;
    logic [DW-1:0] cnt_reg;
    logic [DW-1:0] cnt_next;
    logic [3:0]    dim_reg;

    logic [DW-1:0] dim_ext;
    logic [DW-1:0] deff;
    logic [DW-1:0] dlast;
    logic          row_end;
    logic          col_end;
    logic          load_ok;
    logic [29:0]   load_val;
    mmp_pkg::mmp_ctrl_t ctrl;

    logic [mmp_pkg::MOD_W-1:0] ring_w [MAX_DIM];

    // Clamp the dimension: zero acts as one, anything too large as the maximum
    assign dim_ext = DW'(dim_reg);
    assign deff    = (dim_ext == '0) ? DW'(1) :
                     (dim_ext > DW'(MAX_DIM)) ? DW'(MAX_DIM) : dim_ext;
    assign dlast   = DW'(deff - DW'(1));
    assign row_end = (DW'(row_reg) == dlast);
    assign col_end = (DW'(ocol_reg) == dlast);

    // Drop loads outside the store; reduce values once on entry
    assign load_ok  = ({2'b00, row_index} < DW'(MAX_DIM)) &&
                      ({2'b00, col_index} < DW'(MAX_DIM));
    assign load_val = (entry_value >= mmp_pkg::MOD_P) ?
                      (entry_value - mmp_pkg::MOD_P) : entry_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= 4'd2;
        end
        else if (cfg_write_en)
        begin
            dim_reg <= cfg_write_data;
        end
    end

    // Sequencer: each product walks the rows of the left matrix; for every
    // row the cells load it into the ring, turn it once round the ring
    // through the multipliers, wait for the pipelines to drain, then bank it.
    always_comb
    begin
        state_next = state_reg;
        exp_next   = exp_reg;
        mul_next   = mul_reg;
        row_next   = row_reg;
        ocol_next  = ocol_reg;
        cnt_next   = cnt_reg;

        ctrl         = '0;
        ctrl.dim     = deff;
        ctrl.row     = row_reg;
        ctrl.mul     = mul_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type)
                    begin
                        exp_next   = exponent;
                        state_next = S_INIT;
                    end
                    else if (load_ok)
                    begin
                        ctrl.op    = mmp_pkg::OP_LOAD;
                        ctrl.row   = RW'(row_index);
                        ctrl.col   = RW'(col_index);
                        ctrl.value = load_val;
                    end
                end
            end
            S_INIT:
            begin
                ctrl.op    = mmp_pkg::OP_INIT;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                row_next = '0;
                if (exp_reg == '0)
                begin
                    state_next = S_OLOAD;
                end
                else
                begin
                    mul_next   = exp_reg[0];
                    state_next = S_RING;
                end
            end
            S_RING:
            begin
                ctrl.op    = mmp_pkg::OP_RING;
                cnt_next   = '0;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                ctrl.op = mmp_pkg::OP_ISSUE;
                if (cnt_reg == dlast)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = DW'(cnt_reg + DW'(1));
                end
            end
            S_DRAIN:
            begin
                cnt_next = DW'(cnt_reg + DW'(1));
                if (cnt_reg == DW'(mmp_pkg::DRAIN_CYC - 1))
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                ctrl.op = mmp_pkg::OP_COMMIT;
                if (row_end)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    row_next   = RW'(row_reg + RW'(1));
                    state_next = S_RING;
                end
            end
            S_COPY:
            begin
                ctrl.op  = mmp_pkg::OP_COPY;
                row_next = '0;
                if (mul_reg)
                begin
                    // skip the squaring once no bits remain above this one
                    if (exp_reg[62:1] == '0)
                    begin
                        exp_next   = '0;
                        state_next = S_STEP;
                    end
                    else
                    begin
                        mul_next   = 1'b0;
                        state_next = S_RING;
                    end
                end
                else
                begin
                    exp_next   = {1'b0, exp_reg[62:1]};
                    state_next = S_STEP;
                end
            end
            S_OLOAD:
            begin
                ctrl.op     = mmp_pkg::OP_RING;
                ctrl.src_res = 1'b1;
                ocol_next   = '0;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (col_end)
                    begin
                        if (row_end)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            row_next   = RW'(row_reg + RW'(1));
                            state_next = S_OLOAD;
                        end
                    end
                    else
                    begin
                        ctrl.op   = mmp_pkg::OP_SHIFT;
                        ocol_next = RW'(ocol_reg + RW'(1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            exp_reg   <= '0;
            mul_reg   <= 1'b0;
            row_reg   <= '0;
            ocol_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            exp_reg   <= exp_next;
            mul_reg   <= mul_next;
            row_reg   <= row_next;
            ocol_reg  <= ocol_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Ring of cells: each hands its value to the one below, the first wraps
    // round to the last in use.
    for (genvar j = 0; j < MAX_DIM; j++)
    begin : g_cell
        logic [mmp_pkg::MOD_W-1:0] nbr;
        assign nbr = (DW'(j) == dlast) ? ring_w[0] : ring_w[(j + 1) % MAX_DIM];

        mmp_cell
        #(
            .MAX_DIM (MAX_DIM),
            .CELL_IX (j)
        )
        u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .ring_in  (nbr),
            .ring_out (ring_w[j])
        );
    end

    // Result words come from the head of the ring
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_row   = row_reg[2:0];
    assign out_col   = ocol_reg[2:0];
    assign out_value = ring_w[0];
    assign last      = row_end && col_end;

    // Never take and give words at once
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output both open");

    // Final word sits on the diagonal
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (out_row == out_col))
        else $error("last word off the diagonal");

    // Output values are fully reduced
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_value < mmp_pkg::MOD_P))
        else $error("unreduced result");

    // A start word leads into the set-up cycle
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type) |=> (state_reg == S_INIT))
        else $error("start not taken up");

endmodule
